### design/pcm_sample_format_converter_defines.svh
// ----------------------------------------------------------------------------
// PCM sample format converter assertion macros
// Shared property forms for the checker of the converter.
// ----------------------------------------------------------------------------
`ifndef PCM_SAMPLE_FORMAT_CONVERTER_DEFINES_SVH
`define PCM_SAMPLE_FORMAT_CONVERTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCMFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcmfc check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCMFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcmfc check failed");

`endif

### design/pcmfc_pkg.sv
// ----------------------------------------------------------------------------
// PCM sample format converter package
// Types and constants shared by the converter modules.
// ----------------------------------------------------------------------------
package pcmfc_pkg;

    localparam int SAMPLE_W                 = 64;
    localparam int CFG_INDEX_W              = 2;
    localparam int CFG_DATA_W               = 4;
    localparam int DEFAULT_MAX_SAMPLE_BYTES = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_BYTES   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_BYTES     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLIP_8BIT_SIGN = 2'd3;

    localparam logic [3:0] RESET_SAMPLE_BYTES = 4'd2;

    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_FLOAT  = 2'd1,
        MODE_ALAW   = 2'd2,
        MODE_ULAW   = 2'd3
    } format_mode_t;

    // Class of a float input after decode.
    typedef enum logic [1:0] {
        FC_NORMAL = 2'd0,
        FC_ZERO   = 2'd1,
        FC_NAN    = 2'd2,
        FC_SAT    = 2'd3
    } float_class_t;

    typedef struct packed {
        format_mode_t format_mode;
        logic [3:0]   sample_bytes;
        logic         swap_bytes;
        logic         flip_8bit_sign;
    } cfg_t;

    // Stage data from the decode stage to the finish stage.
    typedef struct packed {
        logic                 keep;
        logic                 is_float;
        logic [SAMPLE_W-1:0]  direct;
        logic                 prod_sign;
        float_class_t         fclass;
        logic                 is_double;
        logic signed [11:0]   exp_unb;
        logic [67:0]          prod;
    } front_t;

endpackage

### design/pcmfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four mode registers written through the configuration channel.
// ----------------------------------------------------------------------------
module pcmfc_cfg_regs
    import pcmfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    // The register file takes a write in every cycle.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register write decode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.format_mode    <= MODE_LINEAR;
            cfg_reg.sample_bytes   <= RESET_SAMPLE_BYTES;
            cfg_reg.swap_bytes     <= 1'b0;
            cfg_reg.flip_8bit_sign <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FORMAT_MODE:    cfg_reg.format_mode    <= format_mode_t'(cfg_data[1:0]);
                CFG_SAMPLE_BYTES:   cfg_reg.sample_bytes   <= cfg_data;
                CFG_SWAP_BYTES:     cfg_reg.swap_bytes     <= cfg_data[0];
                CFG_FLIP_8BIT_SIGN: cfg_reg.flip_8bit_sign <= cfg_data[0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

### design/pcmfc_decode.sv
// ----------------------------------------------------------------------------
// Decode stage
// Finishes linear and companded samples and forms the exact float product.
// ----------------------------------------------------------------------------
module pcmfc_decode
    import pcmfc_pkg::*;
#(
    parameter int MAX_SAMPLE_BYTES = DEFAULT_MAX_SAMPLE_BYTES
)
(
    input  cfg_t                cfg,
    input  logic [SAMPLE_W-1:0] sample_in,
    output front_t              front
);

    localparam logic [3:0] MAX_N      = 4'(MAX_SAMPLE_BYTES);
    localparam logic [7:0] ALAW_XOR   = 8'h55;
    localparam logic [15:0] MULAW_BASE [8] = '{16'd0, 16'd132, 16'd396, 16'd924,
                                               16'd1980, 16'd4092, 16'd8316, 16'd16764};

    // G.711 A-law expansion with the half-step offset.
    function automatic logic [15:0] alaw_expand(input logic [7:0] code);
        logic [7:0]  x;
        logic [2:0]  seg;
        logic [15:0] t;
        x   = code ^ ALAW_XOR;
        seg = x[6:4];
        t   = {8'b0, x[3:0], 4'b0};
        case (seg)
            3'd0:    t = t + 16'd8;
            3'd1:    t = t + 16'h0108;
            default: t = (t + 16'h0108) << 3'(seg - 3'd1);
        endcase
        return x[7] ? t : 16'(~t + 16'd1);
    endfunction

    // G.711 mu-law expansion.
    function automatic logic [15:0] mulaw_expand(input logic [7:0] code);
        logic [7:0]  x;
        logic [2:0]  seg;
        logic [15:0] t;
        x   = ~code;
        seg = x[6:4];
        t   = MULAW_BASE[seg] + ({12'b0, x[3:0]} << (4'(seg) + 4'd3));
        return x[7] ? 16'(~t + 16'd1) : t;
    endfunction

    logic [3:0]  nb;
    logic [7:0]  byte_m  [8];
    logic [63:0] lin;
    logic [52:0] mant;
    logic        exp_ones;
    logic        exp_zero;
    logic        frac_nz;

    // Effective sample width in bytes.
    always_comb
    begin
        nb = cfg.sample_bytes;
        if (nb == 4'd0)
        begin
            nb = 4'd1;
        end
        if (nb > MAX_N)
        begin
            nb = MAX_N;
        end
    end

    // Linear path: mask, optional byte reversal, optional sign flip.
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            byte_m[b] = (4'(b) < nb) ? sample_in[8*b +: 8] : 8'h00;
        end
        for (int j = 0; j < 8; j++)
        begin
            if (!cfg.swap_bytes)
            begin
                lin[8*j +: 8] = byte_m[j];
            end
            else if (4'(j) < nb)
            begin
                lin[8*j +: 8] = byte_m[3'(nb - 4'd1 - 4'(j))];
            end
            else
            begin
                lin[8*j +: 8] = 8'h00;
            end
        end
        if (nb == 4'd1 && cfg.flip_8bit_sign)
        begin
            lin[7] = ~lin[7];
        end
    end

    // Float path: unpack single or double, single mantissa aligned to the top.
    // The same block selects the direct result for the current mode.
    always_comb
    begin
        front.is_double = (nb == 4'd8);
        if (front.is_double)
        begin
            front.prod_sign = sample_in[63];
            exp_ones        = &sample_in[62:52];
            exp_zero        = ~|sample_in[62:52];
            frac_nz         = |sample_in[51:0];
            mant            = {1'b1, sample_in[51:0]};
            front.exp_unb   = $signed(12'({1'b0, sample_in[62:52]}) - 12'd1023);
        end
        else
        begin
            front.prod_sign = sample_in[31];
            exp_ones        = &sample_in[30:23];
            exp_zero        = ~|sample_in[30:23];
            frac_nz         = |sample_in[22:0];
            mant            = {1'b1, sample_in[22:0], 29'b0};
            front.exp_unb   = $signed(12'({4'b0, sample_in[30:23]}) - 12'd127);
        end
        // Times 32767 as a shift and a subtract.
        front.prod = {mant, 15'b0} - {15'b0, mant};
        if (exp_ones)
        begin
            front.fclass = frac_nz ? FC_NAN : FC_SAT;
        end
        else if (exp_zero)
        begin
            front.fclass = FC_ZERO;
        end
        else
        begin
            front.fclass = FC_NORMAL;
        end

        // Mode select for the direct result.
        front.is_float = (cfg.format_mode == MODE_FLOAT);
        front.keep     = 1'b1;
        unique case (cfg.format_mode)
            MODE_LINEAR: front.direct = lin;
            MODE_FLOAT:
            begin
                front.direct = '0;
                front.keep   = (nb == 4'd4) || (nb == 4'd8);
            end
            MODE_ALAW:   front.direct = {48'b0, alaw_expand(sample_in[7:0])};
            MODE_ULAW:   front.direct = {48'b0, mulaw_expand(sample_in[7:0])};
            default:     front.direct = '0;
        endcase
    end

endmodule

### design/pcmfc_float_finish.sv
// ----------------------------------------------------------------------------
// Float finish stage
// Rounds the exact product to source precision, truncates and saturates.
// ----------------------------------------------------------------------------
module pcmfc_float_finish
    import pcmfc_pkg::*;
(
    input  front_t              front,
    output logic [SAMPLE_W-1:0] result
);

    logic               hi;
    logic [52:0]        kept;
    logic               guard;
    logic               sticky;
    logic [5:0]         drop;
    logic [53:0]        qr;
    logic signed [13:0] t;
    logic [63:0]        mag;
    logic               big;
    logic [15:0]        v16;

    // Round to nearest even at the source precision.
    always_comb
    begin
        hi = front.prod[67];
        case ({front.is_double, hi})
            2'b10:
            begin
                kept   = front.prod[66:14];
                guard  = front.prod[13];
                sticky = |front.prod[12:0];
                drop   = 6'd14;
            end
            2'b11:
            begin
                kept   = front.prod[67:15];
                guard  = front.prod[14];
                sticky = |front.prod[13:0];
                drop   = 6'd15;
            end
            2'b00:
            begin
                kept   = {29'b0, front.prod[66:43]};
                guard  = front.prod[42];
                sticky = |front.prod[41:0];
                drop   = 6'd43;
            end
            default:
            begin
                kept   = {29'b0, front.prod[67:44]};
                guard  = front.prod[43];
                sticky = |front.prod[42:0];
                drop   = 6'd44;
            end
        endcase
        qr = {1'b0, kept} + 54'(guard & (sticky | kept[0]));
    end

    // Integer part by a right shift, then saturation to int16.
    always_comb
    begin
        t   = 14'sd52 - 14'(front.exp_unb) - $signed(14'(drop));
        mag = '0;
        big = 1'b0;
        if (t[13])
        begin
            big = 1'b1;
        end
        else if (~|t[12:6])
        begin
            mag = {10'b0, qr} >> t[5:0];
        end
        if (front.fclass == FC_SAT)
        begin
            big = 1'b1;
        end
        if (front.prod_sign)
        begin
            big = big || (|mag[63:15]);
            v16 = big ? 16'h8000 : 16'(~mag[15:0] + 16'd1);
        end
        else
        begin
            big = big || (|mag[63:15]) || (&mag[14:0]);
            v16 = big ? 16'h7FFF : mag[15:0];
        end
        if (front.fclass == FC_NAN || front.fclass == FC_ZERO)
        begin
            v16 = 16'h0000;
        end
        result = front.is_float ? {48'b0, v16} : front.direct;
    end

endmodule

### design/pcm_sample_format_converter.sv
// ----------------------------------------------------------------------------
// PCM sample format converter
// Two-stage pipeline: decode into a stage register, finish into the output.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output side is not stalled and
// returns each result through the stage register, then the output register,
// the decode stage holding the shift-and-subtract product and the finish
// stage the rounding add and the truncating shift. A float sample whose
// width is neither four nor eight bytes is consumed without a result.
module pcm_sample_format_converter
    import pcmfc_pkg::*;
#(
    parameter int MAX_SAMPLE_BYTES = DEFAULT_MAX_SAMPLE_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_W-1:0]    sample_in,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_W-1:0]    sample_out,
    output logic                   out_last
);

    cfg_t                cfg;
    front_t              front;
    front_t              mid_data_reg;
    logic                mid_last_reg;
    logic                mid_valid_reg;
    logic                mid_valid_next;
    logic                mid_adv;
    logic [SAMPLE_W-1:0] result;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic                out_last_reg;
    logic                out_valid_reg;

    pcmfc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcmfc_decode #(
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_decode (
        .cfg       (cfg),
        .sample_in (sample_in),
        .front     (front)
    );

    pcmfc_float_finish u_float_finish (
        .front  (mid_data_reg),
        .result (result)
    );

    // Pipeline flow control.
    assign mid_adv        = !out_valid_reg || out_ready;
    assign in_ready       = !mid_valid_reg || mid_adv;
    assign mid_valid_next = in_valid && front.keep;

    // Stage register valid and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                mid_valid_reg <= mid_valid_next;
            end
            if (mid_adv)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mid_data_reg <= front;
            mid_last_reg <= in_last;
        end
        if (mid_adv && mid_valid_reg)
        begin
            out_data_reg <= result;
            out_last_reg <= mid_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;
    assign out_last   = out_last_reg;

endmodule

### design/pcmfc_checker.sv
// ----------------------------------------------------------------------------
// PCM sample format converter checker
// Port-level assertions, attached to the top level by a bind.
// ----------------------------------------------------------------------------
`include "pcm_sample_format_converter_defines.svh"

module pcmfc_checker
    import pcmfc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [SAMPLE_W-1:0]    sample_in,
    input logic                   in_last,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_W-1:0]    sample_out,
    input logic                   out_last
);

    logic [1:0] mode_reg;
    logic [3:0] bytes_reg;

    // Shadow copy of the mode and width registers seen on the write channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_LINEAR;
            bytes_reg <= RESET_SAMPLE_BYTES;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FORMAT_MODE)
            begin
                mode_reg <= cfg_data[1:0];
            end
            if (cfg_index == CFG_SAMPLE_BYTES)
            begin
                bytes_reg <= cfg_data;
            end
        end
    end

    // A stalled result holds.
    `PCMFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(out_last))

    // With the output register empty the pipeline always takes a request.
    `PCMFC_ASSERT_SAME(a_empty_ready, !out_valid, in_ready)

    // Converted modes fill only the low sixteen bits.
    `PCMFC_ASSERT_SAME(a_int16_upper, out_valid && mode_reg != MODE_LINEAR, sample_out[63:16] == 48'b0)

    // One-byte linear samples fill only the low byte.
    `PCMFC_ASSERT_SAME(a_byte_upper, out_valid && mode_reg == MODE_LINEAR && bytes_reg <= 4'd1, sample_out[63:8] == 56'b0)

endmodule

bind pcm_sample_format_converter pcmfc_checker u_pcmfc_checker (.*);

### sim/pcm_sample_format_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCM sample format converter checker
// Watches the register, request and result channels of the converter. It
// keeps a shadow of the registers, predicts each converted sample and
// compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module pcm_sample_format_checker
    import pcmfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [SAMPLE_W-1:0]    sample_in,
    input  logic                   in_last,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [SAMPLE_W-1:0]    sample_out,
    input  logic                   out_last,
    output int                     errors,
    output int                     pending,
    output int                     results_seen
);

    localparam int          MAX_BYTES   = 8;
    localparam logic [7:0]  ALAW_TOGGLE = 8'h55;
    localparam int          ALAW_SEG1   = 'h108;
    localparam int          ALAW_SEG0   = 8;
    localparam logic [15:0] POS_FULL    = 16'h7FFF;
    localparam logic [15:0] NEG_FULL    = 16'h8000;
    localparam logic [7:0]  SIGN_OFFSET = 8'h80;
    localparam int          SCALE       = 32767;
    localparam int          ULAW_BASE [8] = '{0, 132, 396, 924, 1980, 4092, 8316, 16764};

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } converted_t;

    converted_t   converted_q [$];
    format_mode_t mode_r;
    logic [3:0]   bytes_r;
    logic         swap_r;
    logic         flip_r;

    assign pending = converted_q.size();

    // Clamp a magnitude and sign to the int16 range.
    function automatic logic [15:0] clamp16(logic neg, logic [63:0] mag);
        if (!neg)
            return (mag >= 64'd32767) ? POS_FULL : mag[15:0];
        return (mag >= 64'd32768) ? NEG_FULL : 16'(-mag[15:0]);
    endfunction

    // Single precision scaled by 32767 with the product rounded to 24 bits.
    function automatic logic [15:0] scale_single(logic [31:0] w);
        int          e;
        int          k;
        int          len;
        int          sh;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] mag;
        e = int'(w[30:23]);
        if (e == 255)
            return (w[22:0] != 0) ? 16'h0 : (w[31] ? NEG_FULL : POS_FULL);
        p = {40'd0, (e != 0), w[22:0]} * 64'(SCALE);
        if (e == 0)
            e = 1;
        len = 0;
        for (int i = 0; i < 64; i++)
            if (p[i])
                len = i + 1;
        if (len > 24)
        begin
            k    = len - 24;
            q    = p >> k;
            rem  = p & ((64'd1 << k) - 1);
            half = 64'd1 << (k - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 1;
            p = q << k;
        end
        sh = e - 150;
        if (p == 0 || sh <= -64)
            mag = 0;
        else if (sh >= 16)
            mag = 64'hFFFF_FFFF;
        else if (sh >= 0)
            mag = p << sh;
        else
            mag = p >> (-sh);
        return clamp16(w[31], mag);
    endfunction

    // Double precision scaled by 32767, truncated toward zero.
    function automatic logic [15:0] scale_double(logic [63:0] w);
        real p;
        p = $bitstoreal(w) * 32767.0;
        if (p != p)
            return 16'h0;
        if (p >= 32767.0)
            return POS_FULL;
        if (p <= -32768.0)
            return NEG_FULL;
        return 16'($rtoi(p));
    endfunction

    function automatic logic [15:0] expand_alaw(logic [7:0] code);
        logic [7:0] x;
        int         t;
        int         seg;
        x   = code ^ ALAW_TOGGLE;
        t   = int'(x[3:0]) << 4;
        seg = int'(x[6:4]);
        if (seg == 0)
            t = t + ALAW_SEG0;
        else if (seg == 1)
            t = t + ALAW_SEG1;
        else
            t = (t + ALAW_SEG1) << (seg - 1);
        return x[7] ? 16'(t) : 16'(-t);
    endfunction

    function automatic logic [15:0] expand_ulaw(logic [7:0] code);
        logic [7:0] x;
        int         t;
        int         seg;
        x   = ~code;
        seg = int'(x[6:4]);
        t   = ULAW_BASE[seg] + (int'(x[3:0]) << (seg + 3));
        return x[7] ? 16'(-t) : 16'(t);
    endfunction

    // Predicts one conversion; returns 0 where no result is produced.
    function automatic bit convert_sample(logic [63:0] s, output logic [63:0] r);
        int          n;
        logic [63:0] v;
        n = (bytes_r == 0) ? 1 : ((bytes_r > MAX_BYTES) ? MAX_BYTES : int'(bytes_r));
        r = '0;
        case (mode_r)
            MODE_LINEAR:
            begin
                if (n < 8)
                    s = s & ((64'd1 << (8 * n)) - 1);
                if (swap_r)
                begin
                    v = '0;
                    for (int i = 0; i < n; i++)
                        v[8 * (n - 1 - i) +: 8] = s[8 * i +: 8];
                    s = v;
                end
                if (n == 1 && flip_r)
                    s = {56'd0, s[7:0] - SIGN_OFFSET};
                r = s;
            end
            MODE_FLOAT:
            begin
                if (n == 4)
                    r[15:0] = scale_single(s[31:0]);
                else if (n == 8)
                    r[15:0] = scale_double(s);
                else
                    return 0;
            end
            MODE_ALAW: r[15:0] = expand_alaw(s[7:0]);
            default:   r[15:0] = expand_ulaw(s[7:0]);
        endcase
        return 1;
    endfunction

    task automatic report(string what, logic [63:0] exp_v, logic [63:0] got_v);
        $display("mismatch %s: expected %h, got %h at %0t", what, exp_v, got_v, $realtime);
        errors++;
    endtask

    initial
    begin
        errors       = 0;
        results_seen = 0;
    end

    // Register shadow, prediction and comparison.
    always @(posedge clk or negedge rst_n)
    begin
        converted_t  head;
        logic [63:0] r;
        if (!rst_n)
        begin
            mode_r  = MODE_LINEAR;
            bytes_r = RESET_SAMPLE_BYTES;
            swap_r  = 1'b0;
            flip_r  = 1'b0;
            converted_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (converted_q.size() == 0)
                    report("unexpected result", '0, sample_out);
                else
                begin
                    head = converted_q.pop_front();
                    if (sample_out !== head.sample)
                        report("sample_out", head.sample, sample_out);
                    if (out_last !== head.last)
                        report("out_last", 64'(head.last), 64'(out_last));
                end
            end
            if (in_valid && in_ready && convert_sample(sample_in, r))
                converted_q.push_back('{sample: r, last: in_last});
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FORMAT_MODE:  mode_r  = format_mode_t'(cfg_data[1:0]);
                    CFG_SAMPLE_BYTES: bytes_r = cfg_data;
                    CFG_SWAP_BYTES:   swap_r  = cfg_data[0];
                    default:          flip_r  = cfg_data[0];
                endcase
            end
        end
    end

endmodule

### sim/tb_pcm_sample_format_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PCM sample format converter testbench
// Drives directed and random samples through every format with changing
// register settings and random idling on both sides; a checker beside the
// block predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_pcm_sample_format_converter;
    import pcmfc_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int RAND_PHASES  = 22;
    localparam int PHASE_ITEMS  = 50;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_FORMAT_MODE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [SAMPLE_W-1:0]    sample_in = '0;
    logic                   in_last   = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [SAMPLE_W-1:0]    sample_out;
    logic                   out_last;

    int           errors;
    int           pending;
    int           results_seen;
    int           items_sent = 0;
    int           idle_count = 0;
    bit           tail       = 0;
    bit           hold_req   = 0;
    bit           no_gaps    = 0;
    format_mode_t cur_mode   = MODE_LINEAR;
    logic [3:0]   cur_bytes  = RESET_SAMPLE_BYTES;

    pcm_sample_format_converter i_dut (.*);

    pcm_sample_format_checker i_checker (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_count = 0;
        else if (++idle_count >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_count);
            $display("FAIL pcm_sample_format_converter");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
                out_ready <= 1'b1;
            end
            else if (!tail && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic put(logic [63:0] data, logic last);
        in_valid  <= 1'b1;
        sample_in <= data;
        in_last   <= last;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (!tail && !no_gaps && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_cfg(format_mode_t mode, logic [3:0] nbytes, logic swap, logic flip);
        wait_idle();
        cfg_write(CFG_FORMAT_MODE, CFG_DATA_W'(mode));
        cfg_write(CFG_SAMPLE_BYTES, nbytes);
        cfg_write(CFG_SWAP_BYTES, CFG_DATA_W'(swap));
        cfg_write(CFG_FLIP_8BIT_SIGN, CFG_DATA_W'(flip));
        cur_mode  = mode;
        cur_bytes = nbytes;
    endtask

    // Random sample shaped for the current format.
    function automatic logic [63:0] random_sample();
        logic [63:0] s;
        s = {$urandom, $urandom};
        if (cur_mode == MODE_FLOAT && $urandom_range(0, 9) < 7)
        begin
            if (cur_bytes == 4)
                s[30:23] = 8'($urandom_range(100, 150));
            else
                s[62:52] = 11'($urandom_range(1000, 1050));
        end
        return s;
    endfunction

    initial
    begin
        format_mode_t mode;
        logic [3:0]   nbytes;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings after reset: 16-bit linear pass-through.
        put(64'h0, 1'b0);
        put('1, 1'b1);
        put(64'h0123_4567_89AB_CDEF, 1'b0);

        // 8-bit linear with byte swap and sign flip.
        set_cfg(MODE_LINEAR, 4'd1, 1'b1, 1'b1);
        put(64'h0, 1'b0);
        put(64'h80, 1'b0);
        put(64'hFFFF_FFFF_FFFF_FF7F, 1'b1);

        // Widest linear swap, then the out-of-range widths.
        set_cfg(MODE_LINEAR, 4'd8, 1'b1, 1'b0);
        put(64'h0102_0304_0506_0708, 1'b1);
        set_cfg(MODE_LINEAR, 4'd0, 1'b0, 1'b1);
        put(64'hAAAA_AAAA_AAAA_AA12, 1'b0);
        set_cfg(MODE_LINEAR, 4'd15, 1'b1, 1'b1);
        put(64'h1122_3344_5566_7788, 1'b0);

        // Single precision: zero, ones, infinities, NaN, junk in upper bytes.
        set_cfg(MODE_FLOAT, 4'd4, 1'b0, 1'b0);
        put(64'h0, 1'b0);
        put(64'hDEAD_BEEF_3F80_0000, 1'b0);
        put(64'h0000_0000_BF80_0000, 1'b0);
        put(64'h0000_0000_7FC0_0000, 1'b0);
        put(64'h0000_0000_7F80_0000, 1'b0);
        put(64'h0000_0000_FF80_0000, 1'b1);
        put(64'h0000_0000_3F00_0001, 1'b0);

        // Double precision and a width that gives no result.
        set_cfg(MODE_FLOAT, 4'd8, 1'b0, 1'b0);
        put(64'h3FF0_0000_0000_0000, 1'b0);
        put(64'h7FF8_0000_0000_0000, 1'b0);
        put(64'hC000_0000_0000_0000, 1'b1);
        set_cfg(MODE_FLOAT, 4'd3, 1'b0, 1'b0);
        put(64'h3F80_0000, 1'b1);

        // Companded extremes.
        set_cfg(MODE_ALAW, 4'd2, 1'b0, 1'b0);
        put(64'h0, 1'b0);
        put(64'hFF, 1'b0);
        put(64'h1234_D5, 1'b1);
        set_cfg(MODE_ULAW, 4'd8, 1'b0, 1'b0);
        put(64'h0, 1'b0);
        put(64'hFF, 1'b0);
        put(64'hFF7F, 1'b1);

        // Random settings; one phase fills the block against a held output,
        // and each change of settings waits for every result first.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            mode   = format_mode_t'($urandom_range(0, 3));
            nbytes = 4'($urandom_range(0, 15));
            if (mode == MODE_FLOAT && $urandom_range(0, 9) < 8)
                nbytes = $urandom_range(0, 1) ? 4'd4 : 4'd8;
            else if (mode == MODE_LINEAR && $urandom_range(0, 3) == 0)
                nbytes = 4'd1;
            set_cfg(mode, nbytes, 1'($urandom), 1'($urandom));
            tail    = (ph >= RAND_PHASES - 3);
            no_gaps = (ph == 2);
            if (ph == 2)
                hold_req = 1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                put(random_sample(), 1'($urandom_range(0, 7) == 0));
            no_gaps = 0;
        end

        wait_idle();
        $display("sent %0d samples through all four formats, %0d results checked",
                 items_sent, results_seen);
        if (errors == 0 && pending == 0)
            $display("PASS pcm_sample_format_converter");
        else
            $display("FAIL pcm_sample_format_converter");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/pcmfc_pkg.sv
design/pcmfc_cfg_regs.sv
design/pcmfc_decode.sv
design/pcmfc_float_finish.sv
design/pcm_sample_format_converter.sv
design/pcmfc_checker.sv
sim/pcm_sample_format_checker.sv
sim/tb_pcm_sample_format_converter.sv
